### hw/rtl/column_melt_wipe_tracker_assert.svh
// Assertion macros used by the column melt wipe tracker controller.
`ifndef COLUMN_MELT_WIPE_TRACKER_ASSERT_SVH
`define COLUMN_MELT_WIPE_TRACKER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define CMWT_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cmwt assertion failed");
// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define CMWT_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cmwt assertion failed");
`else
`define CMWT_ASSERT_IMP(lbl, pre, post)
`define CMWT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### hw/rtl/cmwt_pkg.sv
// Shared types and constants of the column melt wipe tracker.
package cmwt_pkg;

	localparam int SCREEN_COLUMNS = 320;
	localparam int SCREEN_ROWS    = 200;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int COL_W    = 9;
	localparam int RAND_W   = 8;
	localparam int HEIGHT_W = 8;
	localparam int OUT_W    = 8;

	// offsets reach the larger of the height cap and a full start height,
	// plus headroom for one advance step
	localparam int MAX_OFS = (SCREEN_ROWS > 255) ? SCREEN_ROWS : 255;
	localparam int OFS_W   = $clog2(MAX_OFS + 17) + 1;
	localparam int ADDR_W  = $clog2(SCREEN_COLUMNS);

	typedef logic signed [OFS_W-1:0] ofs_t;
	typedef logic [ADDR_W-1:0]       addr_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT  = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DRAIN,
		ST_QUERY
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_imm;   // accepted init or unused kind: finish at once
		logic query_rd;   // accepted query: read the column
		logic tick_start; // accepted tick: clear the walk
		logic tick_rd;    // read the next column of the walk
		logic load_query; // load the query result
		logic load_tick;  // load the tick result
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_last;   // walk is reading its last column
	} stat_t;

endpackage

### hw/rtl/cmwt_req_if.sv
// Request channel: valid, ready and one input item.
interface cmwt_req_if;
	logic                        valid;
	logic                        ready;
	logic [cmwt_pkg::KIND_W-1:0] kind;
	logic [cmwt_pkg::COL_W-1:0]  column;
	logic [cmwt_pkg::RAND_W-1:0] rand_value;

	modport source(output valid, kind, column, rand_value, input ready);
	modport sink(input valid, kind, column, rand_value, output ready);
endinterface

### hw/rtl/cmwt_rsp_if.sv
// Response channel: valid, ready and one result item.
interface cmwt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [cmwt_pkg::OUT_W-1:0] offset;
	logic                       done_res;
	logic                       in_wipe;

	modport source(output valid, offset, done_res, in_wipe, input ready);
	modport sink(input valid, offset, done_res, in_wipe, output ready);
endinterface

### hw/rtl/cmwt_ctrl.sv
// Controller state machine of the column melt wipe tracker.
`include "column_melt_wipe_tracker_assert.svh"

module cmwt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [cmwt_pkg::KIND_W-1:0] req_kind,
	output logic                        req_ready,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  cmwt_pkg::stat_t             stat,
	output cmwt_pkg::cmd_t              cmd
);

	cmwt_pkg::state_t state_q, state_d;
	logic             out_v_q, out_v_d;
	logic             accept;

	// hold state and the result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmwt_pkg::ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_v_q <= out_v_d;
		end
	end

	// take a beat only when idle and the result slot is free or draining
	assign req_ready = (state_q == cmwt_pkg::ST_IDLE) && (!out_v_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_v_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cmwt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmwt_pkg::kind_t'(req_kind))
						cmwt_pkg::KIND_TICK: begin
							cmd.tick_start = 1'b1;
							state_d        = cmwt_pkg::ST_TICK;
						end
						cmwt_pkg::KIND_QUERY: begin
							cmd.query_rd = 1'b1;
							state_d      = cmwt_pkg::ST_QUERY;
						end
						default: begin
							cmd.load_imm = 1'b1;
						end
					endcase
				end
			end
			cmwt_pkg::ST_TICK: begin
				cmd.tick_rd = 1'b1;
				if (stat.cnt_last) begin
					state_d = cmwt_pkg::ST_DRAIN;
				end
			end
			cmwt_pkg::ST_DRAIN: begin
				cmd.load_tick = 1'b1;
				state_d       = cmwt_pkg::ST_IDLE;
			end
			cmwt_pkg::ST_QUERY: begin
				cmd.load_query = 1'b1;
				state_d        = cmwt_pkg::ST_IDLE;
			end
			default: begin
				state_d = cmwt_pkg::ST_IDLE;
			end
		endcase
	end

	// set the result flag on a load, drop it once the beat is taken
	always_comb begin
		if (cmd.load_imm || cmd.load_query || cmd.load_tick) begin
			out_v_d = 1'b1;
		end else if (rsp_ready) begin
			out_v_d = 1'b0;
		end else begin
			out_v_d = out_v_q;
		end
	end

	`CMWT_ASSERT_NXT(a_tick_walks, accept && (req_kind == cmwt_pkg::KIND_TICK), state_q == cmwt_pkg::ST_TICK)
	`CMWT_ASSERT_NXT(a_drain_loads, state_q == cmwt_pkg::ST_DRAIN, out_v_q)
	`CMWT_ASSERT_IMP(a_slot_free, (state_q == cmwt_pkg::ST_QUERY) || (state_q == cmwt_pkg::ST_DRAIN), !out_v_q)

endmodule

### hw/rtl/cmwt_dp.sv
// Datapath of the column melt wipe tracker: offset store, walk and result.
module cmwt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmwt_pkg::cmd_t                cmd,
	output cmwt_pkg::stat_t               stat,
	input  logic [cmwt_pkg::KIND_W-1:0]   req_kind,
	input  logic [cmwt_pkg::COL_W-1:0]    req_column,
	input  logic [cmwt_pkg::RAND_W-1:0]   req_rand,
	input  logic                          cfg_we,
	input  logic [cmwt_pkg::HEIGHT_W-1:0] cfg_wdata,
	output logic [cmwt_pkg::OUT_W-1:0]    rsp_offset,
	output logic                          rsp_done,
	output logic                          rsp_in_wipe
);

	localparam int ADDR_W = cmwt_pkg::ADDR_W;
	localparam cmwt_pkg::addr_t LAST_COL = ADDR_W'(cmwt_pkg::SCREEN_COLUMNS - 1);

	// remainder by three of a byte: base-four digits sum to the same residue
	function automatic logic [1:0] mod3(input logic [cmwt_pkg::RAND_W-1:0] x);
		logic [3:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		u = 3'(t[1:0]) + 3'(t[2]);
		if (u >= 3'd3) begin
			u = u - 3'd3;
		end
		return u[1:0];
	endfunction

	// one advance step of a column offset
	function automatic cmwt_pkg::ofs_t advance(input cmwt_pkg::ofs_t v);
		cmwt_pkg::ofs_t dy;
		cmwt_pkg::ofs_t sum;
		cmwt_pkg::ofs_t res;
		dy  = (v < 16) ? v + cmwt_pkg::ofs_t'(1) : cmwt_pkg::ofs_t'(8);
		sum = v + dy;
		if (v < 0) begin
			res = v + cmwt_pkg::ofs_t'(1);
		end else if (v < cmwt_pkg::SCREEN_ROWS) begin
			res = (sum >= cmwt_pkg::SCREEN_ROWS) ?
				cmwt_pkg::ofs_t'(cmwt_pkg::SCREEN_ROWS) : sum;
		end else begin
			res = v;
		end
		return res;
	endfunction

	cmwt_pkg::ofs_t mem_q [cmwt_pkg::SCREEN_COLUMNS];

	logic [cmwt_pkg::HEIGHT_W-1:0] start_q;
	cmwt_pkg::ofs_t                prev_q;
	logic                          wipe_q;
	cmwt_pkg::addr_t               cnt_q;
	logic                          moved_q;

	logic                          tick_v_s1;
	cmwt_pkg::addr_t               addr_s1;
	cmwt_pkg::ofs_t                rd_s1;
	logic                          q_ok_s1;

	logic [ADDR_W+cmwt_pkg::COL_W-1:0] col_ext;
	cmwt_pkg::addr_t                   col_addr;
	logic                              col_ok;
	logic                              is_init;
	logic                              init_we;
	logic                              wipe_next;
	cmwt_pkg::ofs_t                    v_first;
	cmwt_pkg::ofs_t                    v_chain;
	cmwt_pkg::ofs_t                    v_init;
	cmwt_pkg::ofs_t                    v_tick;
	logic                              mv_s1;

	logic                              we;
	cmwt_pkg::addr_t                   waddr;
	cmwt_pkg::ofs_t                    wdata;
	logic                              re;
	cmwt_pkg::addr_t                   raddr;

	// decode the column of the request
	assign col_ext  = {{ADDR_W{1'b0}}, req_column};
	assign col_addr = col_ext[ADDR_W-1:0];
	assign col_ok   = 32'(req_column) < cmwt_pkg::SCREEN_COLUMNS;
	assign is_init  = req_kind == cmwt_pkg::KIND_INIT;
	assign init_we  = cmd.load_imm && is_init && col_ok;

	// init values: column zero from the start height, others chained
	always_comb begin
		v_first = cmwt_pkg::ofs_t'({1'b0, start_q}) - cmwt_pkg::ofs_t'({1'b0, req_rand[3:0]});
		v_chain = prev_q + cmwt_pkg::ofs_t'({1'b0, mod3(req_rand)}) - cmwt_pkg::ofs_t'(1);
		if (v_chain > 0) begin
			v_chain = '0;
		end else if (v_chain == -16) begin
			v_chain = cmwt_pkg::ofs_t'(-15);
		end
		v_init    = (req_column == '0) ? v_first : v_chain;
		wipe_next = (init_we && (req_column == '0)) ? 1'b1 : wipe_q;
	end

	// advance the column read in the previous cycle
	assign v_tick = advance(rd_s1);
	assign mv_s1  = tick_v_s1 && (v_tick != rd_s1);

	// share the single write port and the single read port
	assign we    = init_we || tick_v_s1;
	assign waddr = tick_v_s1 ? addr_s1 : col_addr;
	assign wdata = tick_v_s1 ? v_tick : v_init;
	assign re    = (cmd.query_rd && col_ok) || cmd.tick_rd;
	assign raddr = cmd.tick_rd ? cnt_q : col_addr;

	assign stat.cnt_last = cnt_q == LAST_COL;

	// store write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_s1 <= mem_q[raddr];
		end
		if (cmd.tick_rd) begin
			addr_s1 <= cnt_q;
		end
		if (cmd.query_rd) begin
			q_ok_s1 <= col_ok;
		end
	end

	// hold height, chain, flag and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			prev_q    <= '0;
			wipe_q    <= 1'b0;
			cnt_q     <= '0;
			moved_q   <= 1'b0;
			tick_v_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (init_we) begin
				prev_q <= v_init;
			end
			tick_v_s1 <= cmd.tick_rd;
			if (cmd.tick_start) begin
				cnt_q   <= '0;
				moved_q <= 1'b0;
			end else begin
				if (cmd.tick_rd) begin
					cnt_q <= cnt_q + ADDR_W'(1);
				end
				if (mv_s1) begin
					moved_q <= 1'b1;
				end
			end
			if (cmd.load_imm) begin
				wipe_q <= wipe_next;
			end else if (cmd.load_tick && !(moved_q || mv_s1)) begin
				wipe_q <= 1'b0;
			end
		end
	end

	// load the result beat
	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			rsp_offset  <= '0;
			rsp_done    <= 1'b0;
			rsp_in_wipe <= wipe_next;
		end else if (cmd.load_query) begin
			if (!q_ok_s1 || (rd_s1 < 0)) begin
				rsp_offset <= '0;
			end else if (rd_s1 > 255) begin
				rsp_offset <= '1;
			end else begin
				rsp_offset <= rd_s1[cmwt_pkg::OUT_W-1:0];
			end
			rsp_done    <= 1'b0;
			rsp_in_wipe <= wipe_q;
		end else if (cmd.load_tick) begin
			rsp_offset  <= '0;
			rsp_done    <= !(moved_q || mv_s1);
			rsp_in_wipe <= (moved_q || mv_s1) ? wipe_q : 1'b0;
		end
	end

endmodule

### hw/rtl/column_melt_wipe_tracker.sv
// Top level of the column melt wipe tracker.
//
//  port   dir  beat contents
//  req    in   kind, column, rand_value
//  rsp    out  offset, done_res, in_wipe
//  cfg    in   start_height write (cfg_we, cfg_wdata)
//
// Init and the unused kind finish at the accepting edge. A query first reads
// the store through its registered read port, then loads the result beat.
// A tick walks every column: it reads one column a cycle through the single
// read port of the offset store and writes it back in the following cycle.
// Reset clears control only; the store is not cleared.
// The request side is not ready while a result beat waits untaken.
module column_melt_wipe_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	cmwt_req_if.sink                      req,
	cmwt_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [cmwt_pkg::HEIGHT_W-1:0] cfg_wdata
);

	cmwt_pkg::cmd_t  cmd;
	cmwt_pkg::stat_t stat;

	cmwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cmwt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_kind    (req.kind),
		.req_column  (req.column),
		.req_rand    (req.rand_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rsp_offset  (rsp.offset),
		.rsp_done    (rsp.done_res),
		.rsp_in_wipe (rsp.in_wipe)
	);

endmodule
